### design/fvn_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// fvn_pkg: shared constants, types and cosine table for the fractal noise core
// Widths of every pipeline word, the hash constants, the register indexes and
// the (1-cos(pi*t))/2 weight table built at elaboration.
// ============================================================================
package fvn_pkg;

    localparam int MAX_OCTAVES    = 16;
    localparam int COS_TABLE_BITS = 10;
    localparam int COS_ENTRIES    = 1 << COS_TABLE_BITS;

    localparam int OCT_LOG  = $clog2(MAX_OCTAVES);
    localparam int TREE_N   = 1 << OCT_LOG;
    localparam int CNT_W    = $clog2(MAX_OCTAVES + 1);

    // Datapath widths
    localparam int FRAC_W   = 17;                    // weight 0..65536
    localparam int LAT_W    = 32;                    // lattice value, Q30
    localparam int SM_W     = 36;                    // smoothed value, Q34
    localparam int BLEND_W  = SM_W + FRAC_W + 2;     // blend product
    localparam int AMP_W    = 17;                    // amplitude 0..65536
    localparam int SUM_W    = SM_W + AMP_W + 1 + OCT_LOG;
    localparam int NORM_W   = AMP_W + OCT_LOG;
    localparam int DIV_W    = SUM_W;
    localparam int DEN_SHIFT = 18;
    localparam int Q_W      = 18;
    localparam int OCT_LAT  = 11;
    localparam int SETTLE   = MAX_OCTAVES + 4;
    localparam int SETTLE_W = $clog2(SETTLE + 1);

    // Hash constants
    localparam logic [31:0] HASH_MUL_A = 32'd15731;
    localparam logic [31:0] HASH_ADD_B = 32'd789221;
    localparam logic [31:0] HASH_ADD_C = 32'd1376312589;
    localparam logic signed [LAT_W-1:0] LAT_ONE = 32'sd1073741824;

    localparam logic [AMP_W-1:0] AMP_ONE    = 17'd65536;
    localparam logic [Q_W-1:0]   NOISE_MAX  = 18'd65536;
    localparam logic [4:0]       OCT_RESET  = 5'd10;
    localparam logic [15:0]      PERS_RESET = 16'd32768;

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    // Taylor term divisors (2k-1)*2k for k = 1..10
    localparam longint unsigned TAYLOR_DIV [10] = '{
        64'd2, 64'd12, 64'd30, 64'd56, 64'd90,
        64'd132, 64'd182, 64'd240, 64'd306, 64'd380
    };

    typedef enum logic {
        REG_OCTAVE_COUNT = 1'b0,
        REG_PERSISTENCE  = 1'b1
    } cfg_reg_t;

    typedef logic [FRAC_W-1:0] cos_rom_t [COS_ENTRIES];

    // Build the interpolation weight table: Taylor cosine in Q30, mirrored
    // above one half, clamped, then rounded half up to Q16.
    function automatic cos_rom_t build_cos_rom();
        cos_rom_t rom;
        longint unsigned u;
        longint unsigned ue;
        longint unsigned a;
        longint unsigned a2;
        longint unsigned term;
        longint sum;
        longint f;
        for (int k = 0; k < COS_ENTRIES; k++) begin
            u = longint'(k) << (30 - COS_TABLE_BITS);
            ue = (u > (ONE_Q30 >> 1)) ? (ONE_Q30 - u) : u;
            a = (ue * PI_Q30) >> 30;
            a2 = (a * a) >> 30;
            term = ONE_Q30;
            sum = longint'(ONE_Q30);
            for (int j = 1; j <= 10; j++) begin
                term = ((term * a2) >> 30) / TAYLOR_DIV[j-1];
                if ((j & 1) == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (u > (ONE_Q30 >> 1)) begin
                f = (longint'(ONE_Q30) + sum) / 2;
            end else begin
                f = (longint'(ONE_Q30) - sum) / 2;
            end
            if (f < 0) begin
                f = 0;
            end
            if (f > longint'(ONE_Q30)) begin
                f = longint'(ONE_Q30);
            end
            rom[k] = FRAC_W'((f + 8192) >>> 14);
        end
        return rom;
    endfunction

    localparam cos_rom_t COS_ROM = build_cos_rom();

endpackage

### design/fractal_value_noise_2d.sv
`timescale 1ns / 1ps
// ============================================================================
// fractal_value_noise_2d: fractal value noise of a 2D point
// Takes Q16.16 coordinate pairs and returns one Q16 noise value per pair,
// in order. At MAX_OCTAVES = 16 the path has 11 octave stages, one
// weighting stage, a four-level adder tree, one sign stage, 18 divider
// stages and the output register; all octaves run in parallel, so one item
// enters every clock unless the output stalls or the input is held off,
// and the divider bit stages set the depth. The per-octave amplitudes and
// their sum come from a register chain fed by the configuration; after
// reset and after every register write the input is held off while that
// chain settles. Octave count zero acts as one, counts above 16 act as 16.
// ============================================================================
module fractal_value_noise_2d (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,     // [31:0] x_pos, [63:32] y_pos
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,     // [17:0] noise_value, [23:18] zero
    input  logic        cfg_we,
    input  logic [0:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int VLD_N = fvn_pkg::OCT_LAT + fvn_pkg::OCT_LOG + fvn_pkg::Q_W + 2;

    logic [4:0]  oct_cnt_reg;
    logic [15:0] pers_reg;
    logic [fvn_pkg::CNT_W-1:0] cnt_eff;
    logic [fvn_pkg::SETTLE_W-1:0] settle_reg;

    logic [fvn_pkg::AMP_W-1:0]  amp_reg     [fvn_pkg::MAX_OCTAVES];
    logic [fvn_pkg::AMP_W-1:0]  amp_eff_reg [fvn_pkg::MAX_OCTAVES];
    logic [fvn_pkg::NORM_W-1:0] part_reg    [fvn_pkg::MAX_OCTAVES];
    logic [fvn_pkg::NORM_W-1:0] norm;

    logic adv;
    logic take;
    logic [VLD_N-1:0] vld_reg;
    logic [63:0] x_ext;
    logic [63:0] y_ext;

    logic signed [fvn_pkg::SM_W-1:0]  oct_val  [fvn_pkg::MAX_OCTAVES];
    logic signed [fvn_pkg::SUM_W-1:0] tree_reg [fvn_pkg::OCT_LOG+1][fvn_pkg::TREE_N];
    logic signed [fvn_pkg::SUM_W-1:0] total;
    logic [fvn_pkg::DIV_W-1:0] num_reg;
    logic neg_reg;
    logic [fvn_pkg::Q_W-1:0] quo;
    logic neg_q;
    logic [fvn_pkg::Q_W-1:0] mag_c;
    logic [fvn_pkg::Q_W-1:0] noise_reg;
    logic m_tvalid_reg;

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            oct_cnt_reg <= fvn_pkg::OCT_RESET;
            pers_reg    <= fvn_pkg::PERS_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                fvn_pkg::REG_OCTAVE_COUNT: oct_cnt_reg <= cfg_wdata[4:0];
                fvn_pkg::REG_PERSISTENCE:  pers_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Clamp the octave count to the supported range
    always_comb begin
        if (oct_cnt_reg == '0) begin
            cnt_eff = fvn_pkg::CNT_W'(1);
        end else if (32'(oct_cnt_reg) > fvn_pkg::MAX_OCTAVES) begin
            cnt_eff = fvn_pkg::CNT_W'(fvn_pkg::MAX_OCTAVES);
        end else begin
            cnt_eff = fvn_pkg::CNT_W'(oct_cnt_reg);
        end
    end

    // Amplitude chain, masked amplitudes and their running sum
    always_ff @(posedge aclk) begin
        amp_reg[0] <= fvn_pkg::AMP_ONE;
        for (int k = 1; k < fvn_pkg::MAX_OCTAVES; k++) begin
            amp_reg[k] <= fvn_pkg::AMP_W'(({16'b0, amp_reg[k-1]} * {17'b0, pers_reg}) >> 16);
        end
        for (int k = 0; k < fvn_pkg::MAX_OCTAVES; k++) begin
            amp_eff_reg[k] <= (fvn_pkg::CNT_W'(k) < cnt_eff) ? amp_reg[k] : '0;
        end
        part_reg[0] <= fvn_pkg::NORM_W'(amp_eff_reg[0]);
        for (int k = 1; k < fvn_pkg::MAX_OCTAVES; k++) begin
            part_reg[k] <= part_reg[k-1] + fvn_pkg::NORM_W'(amp_eff_reg[k]);
        end
    end

    assign norm = part_reg[fvn_pkg::MAX_OCTAVES-1];

    // Hold off requests until the amplitude chain has settled
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            settle_reg <= fvn_pkg::SETTLE_W'(fvn_pkg::SETTLE);
        end else if (cfg_we) begin
            settle_reg <= fvn_pkg::SETTLE_W'(fvn_pkg::SETTLE);
        end else if (settle_reg != '0) begin
            settle_reg <= settle_reg - 1'b1;
        end
    end

    // Whole pipeline advances unless a finished result is waiting
    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv && (settle_reg == '0);
    assign take     = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            vld_reg      <= {vld_reg[VLD_N-2:0], take};
            m_tvalid_reg <= vld_reg[VLD_N-1];
        end
    end

    assign x_ext = {{32{s_tdata[31]}}, s_tdata[31:0]};
    assign y_ext = {{32{s_tdata[63]}}, s_tdata[63:32]};

    // One octave unit per frequency, coordinates scaled by 2^k
    for (genvar k = 0; k < fvn_pkg::MAX_OCTAVES; k++) begin : g_oct
        logic [63:0] sx;
        logic [63:0] sy;

        assign sx = x_ext << k;
        assign sy = y_ext << k;

        fvn_octave u_oct (
            .aclk       (aclk),
            .en         (adv),
            .lat_x      (sx[47:16]),
            .lat_y      (sy[47:16]),
            .frac_x_idx (sx[15 -: fvn_pkg::COS_TABLE_BITS]),
            .frac_y_idx (sy[15 -: fvn_pkg::COS_TABLE_BITS]),
            .oct_value  (oct_val[k])
        );
    end

    // Weight each octave and add them in a registered tree
    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int k = 0; k < fvn_pkg::TREE_N; k++) begin
                if (k < fvn_pkg::MAX_OCTAVES) begin
                    tree_reg[0][k] <= fvn_pkg::SUM_W'(oct_val[k])
                                    * fvn_pkg::SUM_W'($signed({1'b0, amp_eff_reg[k]}));
                end else begin
                    tree_reg[0][k] <= '0;
                end
            end
            for (int lv = 1; lv <= fvn_pkg::OCT_LOG; lv++) begin
                for (int i = 0; i < fvn_pkg::TREE_N; i++) begin
                    if (2 * i + 1 < fvn_pkg::TREE_N) begin
                        tree_reg[lv][i] <= tree_reg[lv-1][2*i] + tree_reg[lv-1][2*i+1];
                    end else begin
                        tree_reg[lv][i] <= '0;
                    end
                end
            end
        end
    end

    assign total = tree_reg[fvn_pkg::OCT_LOG][0];

    // Split off the sign and add half the divisor for rounding
    always_ff @(posedge aclk) begin
        if (adv) begin
            neg_reg <= total[fvn_pkg::SUM_W-1];
            num_reg <= (total[fvn_pkg::SUM_W-1] ? fvn_pkg::DIV_W'(-total)
                                                : fvn_pkg::DIV_W'(total))
                     + (fvn_pkg::DIV_W'(norm) << (fvn_pkg::DEN_SHIFT - 1));
        end
    end

    fvn_div u_div (
        .aclk    (aclk),
        .en      (adv),
        .num_in  (num_reg),
        .norm    (norm),
        .neg_in  (neg_reg),
        .quo_out (quo),
        .neg_out (neg_q)
    );

    // Clamp, restore the sign and hold the result
    assign mag_c = (quo > fvn_pkg::NOISE_MAX) ? fvn_pkg::NOISE_MAX : quo;

    always_ff @(posedge aclk) begin
        if (adv) begin
            noise_reg <= neg_q ? (~mag_c + 1'b1) : mag_c;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {6'b0, noise_reg};

    // A delivered value lies within minus one to one
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> ($signed(noise_reg) <= 18'sd65536 && $signed(noise_reg) >= -18'sd65536))
        else $error("noise value out of range");

    // A register write closes the input while amplitudes settle
    a_cfg_holdoff: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_we |=> !s_tready)
        else $error("input accepted right after a register write");

    // A stalled output freezes every item in flight
    a_stall_freeze: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> $stable(vld_reg))
        else $error("pipeline moved during a stall");

endmodule

### design/fvn_octave.sv
`timescale 1ns / 1ps
// ============================================================================
// fvn_octave: one octave of value noise
// Hashes the 4x4 lattice neighborhood, smooths the four cell corners over
// their 3x3 neighbors and blends them with cosine weights. Eleven stages.
// ============================================================================
module fvn_octave (
    input  logic                                  aclk,
    input  logic                                  en,
    input  logic [31:0]                           lat_x,
    input  logic [31:0]                           lat_y,
    input  logic [fvn_pkg::COS_TABLE_BITS-1:0]    frac_x_idx,
    input  logic [fvn_pkg::COS_TABLE_BITS-1:0]    frac_y_idx,
    output logic signed [fvn_pkg::SM_W-1:0]       oct_value
);

    logic [31:0] px [4];
    logic [31:0] py [4];
    logic [31:0] n0 [16];
    logic [31:0] nh [16];

    logic [31:0] n1_reg  [16];
    logic [31:0] sq2_reg [16];
    logic [31:0] n2_reg  [16];
    logic [31:0] t3_reg  [16];
    logic [31:0] n3_reg  [16];
    logic [31:0] m4_reg  [16];
    logic signed [fvn_pkg::LAT_W-1:0] lat5_reg [16];
    logic signed [fvn_pkg::LAT_W+1:0] cor6_reg [4];
    logic signed [fvn_pkg::LAT_W+1:0] sid6_reg [4];
    logic signed [fvn_pkg::LAT_W-1:0] cen6_reg [4];
    logic signed [fvn_pkg::SM_W-1:0]  sm7_reg  [4];
    logic signed [fvn_pkg::SM_W-1:0]  bx8_reg  [2];
    logic signed [fvn_pkg::BLEND_W-1:0] px8_reg [2];
    logic signed [fvn_pkg::SM_W-1:0]  h9_reg   [2];
    logic signed [fvn_pkg::SM_W-1:0]  by10_reg;
    logic signed [fvn_pkg::BLEND_W-1:0] py10_reg;
    logic signed [fvn_pkg::SM_W-1:0]  r11_reg;
    logic [fvn_pkg::FRAC_W-1:0] fx_reg [7];
    logic [fvn_pkg::FRAC_W-1:0] fy_reg [9];

    // Neighborhood coordinates and the first hash mix
    always_comb begin
        for (int g = 0; g < 4; g++) begin
            px[g] = lat_x + 32'(g) - 32'd1;
            py[g] = lat_y + 32'(g) - 32'd1;
        end
        for (int p = 0; p < 16; p++) begin
            n0[p] = px[p & 3] + (py[p >> 2] << 6) - (py[p >> 2] << 3) + py[p >> 2];
            nh[p] = (n0[p] << 13) ^ n0[p];
        end
    end

    // Hash stages: square, polynomial, product, fold to Q30
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int p = 0; p < 16; p++) begin
                n1_reg[p]  <= nh[p];
                sq2_reg[p] <= n1_reg[p] * n1_reg[p];
                n2_reg[p]  <= n1_reg[p];
                t3_reg[p]  <= sq2_reg[p] * fvn_pkg::HASH_MUL_A + fvn_pkg::HASH_ADD_B;
                n3_reg[p]  <= n2_reg[p];
                m4_reg[p]  <= n3_reg[p] * t3_reg[p];
                lat5_reg[p] <= fvn_pkg::LAT_ONE
                             - $signed({1'b0, 31'(m4_reg[p] + fvn_pkg::HASH_ADD_C)});
            end
        end
    end

    // Weight lookup, then carry the weights beside the lattice data
    always_ff @(posedge aclk) begin
        if (en) begin
            fx_reg[0] <= fvn_pkg::COS_ROM[frac_x_idx];
            fy_reg[0] <= fvn_pkg::COS_ROM[frac_y_idx];
            for (int i = 1; i < 7; i++) begin
                fx_reg[i] <= fx_reg[i-1];
            end
            for (int i = 1; i < 9; i++) begin
                fy_reg[i] <= fy_reg[i-1];
            end
        end
    end

    // Smooth each cell corner over its 3x3 neighbors
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int c = 0; c < 4; c++) begin
                cor6_reg[c] <= 34'(lat5_reg[(c >> 1)*4 + (c & 1)])
                             + 34'(lat5_reg[(c >> 1)*4 + (c & 1) + 2])
                             + 34'(lat5_reg[((c >> 1) + 2)*4 + (c & 1)])
                             + 34'(lat5_reg[((c >> 1) + 2)*4 + (c & 1) + 2]);
                sid6_reg[c] <= 34'(lat5_reg[((c >> 1) + 1)*4 + (c & 1)])
                             + 34'(lat5_reg[((c >> 1) + 1)*4 + (c & 1) + 2])
                             + 34'(lat5_reg[(c >> 1)*4 + (c & 1) + 1])
                             + 34'(lat5_reg[((c >> 1) + 2)*4 + (c & 1) + 1]);
                cen6_reg[c] <= lat5_reg[((c >> 1) + 1)*4 + (c & 1) + 1];
                sm7_reg[c]  <= fvn_pkg::SM_W'(cor6_reg[c])
                             + (fvn_pkg::SM_W'(sid6_reg[c]) <<< 1)
                             + (fvn_pkg::SM_W'(cen6_reg[c]) <<< 2);
            end
        end
    end

    // Blend along x for both rows, then along y
    always_ff @(posedge aclk) begin
        if (en) begin
            for (int r = 0; r < 2; r++) begin
                bx8_reg[r] <= sm7_reg[2*r];
                px8_reg[r] <= (fvn_pkg::BLEND_W'(sm7_reg[2*r+1])
                             - fvn_pkg::BLEND_W'(sm7_reg[2*r]))
                            * fvn_pkg::BLEND_W'($signed({1'b0, fx_reg[6]}));
                h9_reg[r]  <= bx8_reg[r] + fvn_pkg::SM_W'(px8_reg[r] >>> 16);
            end
            by10_reg <= h9_reg[0];
            py10_reg <= (fvn_pkg::BLEND_W'(h9_reg[1]) - fvn_pkg::BLEND_W'(h9_reg[0]))
                      * fvn_pkg::BLEND_W'($signed({1'b0, fy_reg[8]}));
            r11_reg  <= by10_reg + fvn_pkg::SM_W'(py10_reg >>> 16);
        end
    end

    assign oct_value = r11_reg;

endmodule

### design/fvn_div.sv
`timescale 1ns / 1ps
// ============================================================================
// fvn_div: pipelined restoring divider for the normalization
// Divides the rounded magnitude by norm * 2^18, one quotient bit per stage.
// ============================================================================
module fvn_div (
    input  logic                              aclk,
    input  logic                              en,
    input  logic [fvn_pkg::DIV_W-1:0]         num_in,
    input  logic [fvn_pkg::NORM_W-1:0]        norm,
    input  logic                              neg_in,
    output logic [fvn_pkg::Q_W-1:0]           quo_out,
    output logic                              neg_out
);

    logic [fvn_pkg::DIV_W-1:0] rem_reg [fvn_pkg::Q_W];
    logic [fvn_pkg::Q_W-1:0]   quo_reg [fvn_pkg::Q_W];
    logic [fvn_pkg::Q_W-1:0]   neg_reg;

    for (genvar s = 0; s < fvn_pkg::Q_W; s++) begin : g_stage
        logic [fvn_pkg::DIV_W-1:0] rem_in;
        logic [fvn_pkg::DIV_W-1:0] dsh;
        logic [fvn_pkg::Q_W-1:0]   quo_in;
        logic                      neg_s;
        logic                      fits;

        if (s == 0) begin : g_first
            assign rem_in = num_in;
            assign quo_in = '0;
            assign neg_s  = neg_in;
        end else begin : g_next
            assign rem_in = rem_reg[s-1];
            assign quo_in = quo_reg[s-1];
            assign neg_s  = neg_reg[s-1];
        end

        // Trial subtract of the divisor aligned to this quotient bit
        assign dsh  = fvn_pkg::DIV_W'(norm) << (fvn_pkg::DEN_SHIFT + fvn_pkg::Q_W - 1 - s);
        assign fits = (rem_in >= dsh);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[s] <= fits ? (rem_in - dsh) : rem_in;
                quo_reg[s] <= {quo_in[fvn_pkg::Q_W-2:0], fits};
                neg_reg[s] <= neg_s;
            end
        end
    end

    assign quo_out = quo_reg[fvn_pkg::Q_W-1];
    assign neg_out = neg_reg[fvn_pkg::Q_W-1];

endmodule
